// ===== rtl/core/dnsdec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS name decoder package
// Shared types, codes and fixed widths of the DNS name label decoder.
// ----------------------------------------------------------------------------
package dnsdec_pkg;

  localparam int RPW  = 14;
  localparam int LENW = 10;
  localparam int ADW  = 9;
  localparam int CHW  = 8;

  localparam logic       MODE_WRITE  = 1'b0;
  localparam logic       MODE_DECODE = 1'b1;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_LONG = 2'd1;
  localparam logic [1:0] ERR_HOPS = 2'd2;
  localparam logic [1:0] ERR_READ = 2'd3;

  localparam logic [1:0] TAG_LABEL   = 2'b00;
  localparam logic [1:0] TAG_POINTER = 2'b11;

  localparam logic [CHW-1:0] CHAR_DOT = 8'h2E;

  typedef struct packed {
    logic           mode;
    logic [ADW-1:0] address;
    logic [CHW-1:0] data;
  } in_req_t;

  typedef struct packed {
    logic [CHW-1:0] text_char0;
    logic [CHW-1:0] text_char1;
    logic [CHW-1:0] text_char2;
    logic [CHW-1:0] text_char3;
    logic [2:0]     char_count;
    logic           last;
    logic [8:0]     consumed_bytes;
    logic [1:0]     error_code;
  } out_rsp_t;

  typedef struct packed {
    logic           en;
    logic [ADW-1:0] addr;
    logic [CHW-1:0] data;
  } msg_wr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HEAD_RD,
    S_HEAD,
    S_PTR,
    S_LAB_RD,
    S_LAB,
    S_GRD,
    S_GCH,
    S_EMIT,
    S_ERR
  } dec_state_t;

endpackage

// ===== rtl/core/dnsdec_msg_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS message byte store
// Single-port write, registered read byte memory with loaded length tracking.
// ----------------------------------------------------------------------------
module dnsdec_msg_store
  import dnsdec_pkg::*;
#(
  parameter int MSG_BYTES = 512
) (
  input  logic            clk,
  input  logic            rst_n,
  input  msg_wr_t         wr,
  input  logic [RPW-1:0]  rd_addr,
  output logic [CHW-1:0]  rd_data,
  output logic [LENW-1:0] loaded_len
);

  localparam int AW = $clog2(MSG_BYTES);
  localparam int ZW = RPW + 1;

  logic [CHW-1:0]  mem [MSG_BYTES];
  logic [CHW-1:0]  rd_data_r;
  logic [LENW-1:0] len_r;
  logic [LENW-1:0] len_nxt;
  logic            wr_ok;
  logic [LENW-1:0] wr_end;

  assign wr_ok  = wr.en && (ZW'(wr.addr) < ZW'(MSG_BYTES));
  assign wr_end = LENW'(wr.addr) + LENW'(1);

  always_comb begin
    len_nxt = len_r;
    if (wr_ok && (wr_end > len_r)) begin
      len_nxt = wr_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[AW'(wr.addr)] <= wr.data;
    end
    rd_data_r <= mem[rd_addr[AW-1:0]];
  end

  assign rd_data    = rd_data_r;
  assign loaded_len = len_r;

endmodule

// ===== rtl/core/dns_name_label_decoder_top.sv =====
`timescale 1ns / 1ps
// A write request goes straight to the store. A decode request walks the name byte by byte
// through the single store read port, then emits four-character groups character by character
// through the text buffer read port.
// The block stalls its input for the whole decode; an error result follows the failing byte.
// Synchronous active-low reset clears the loaded length and all control state.
// ----------------------------------------------------------------------------
// DNS name label decoder
// Loads message bytes, then walks labels and compression pointers of a name
// and returns its dotted text up to four characters per result, or an error result.
// ----------------------------------------------------------------------------
module dns_name_label_decoder_top
  import dnsdec_pkg::*;
#(
  parameter int MSG_BYTES = 512,
  parameter int NAME_MAX  = 256,
  parameter int MAX_HOPS  = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_rsp
);

  localparam int TW  = $clog2(NAME_MAX);
  localparam int ZW  = RPW + 1;

  dec_state_t      state_r, state_nxt;
  logic [RPW-1:0]  rp_r, rp_nxt;
  logic [ADW-1:0]  start_r, start_nxt;
  logic [5:0]      rem_r, rem_nxt;
  logic [7:0]      tl_r, tl_nxt;
  logic [4:0]      hop_r, hop_nxt;
  logic [8:0]      cons_r, cons_nxt;
  logic            jmp_r, jmp_nxt;
  logic [5:0]      phi_r, phi_nxt;
  logic [7:0]      pos_r, pos_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [1:0]      err_r, err_nxt;
  logic [CHW-1:0]  grp_r [4];
  logic [CHW-1:0]  grp_nxt [4];

  logic            out_valid_r, out_valid_nxt;
  out_rsp_t        out_rsp_r, out_rsp_nxt;
  logic            out_free;

  msg_wr_t         mwr;
  logic [RPW-1:0]  mrd_addr;
  logic [CHW-1:0]  mrd_data;
  logic [LENW-1:0] loaded_len;
  logic            rp_past;
  logic            rp1_past;

  logic [CHW-1:0]  txt_mem [NAME_MAX];
  logic [CHW-1:0]  txt_rd_r;
  logic            txt_we;
  logic [CHW-1:0]  txt_wd;
  logic            in_take;
  logic            name_full;

  dnsdec_msg_store #(
    .MSG_BYTES(MSG_BYTES)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (mwr),
    .rd_addr   (mrd_addr),
    .rd_data   (mrd_data),
    .loaded_len(loaded_len)
  );

  assign in_take   = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign rp_past   = ZW'(rp_r) >= ZW'(loaded_len);
  assign rp1_past  = (ZW'(rp_r) + ZW'(1)) >= ZW'(loaded_len);
  assign name_full = tl_r >= 8'(NAME_MAX - 1);

  assign mwr.en   = in_take && (in_req.mode == MODE_WRITE);
  assign mwr.addr = in_req.address;
  assign mwr.data = in_req.data;

  always_comb begin
    state_nxt     = state_r;
    rp_nxt        = rp_r;
    start_nxt     = start_r;
    rem_nxt       = rem_r;
    tl_nxt        = tl_r;
    hop_nxt       = hop_r;
    cons_nxt      = cons_r;
    jmp_nxt       = jmp_r;
    phi_nxt       = phi_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    grp_nxt       = grp_r;
    mrd_addr      = rp_r;
    txt_we        = 1'b0;
    txt_wd        = mrd_data;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_take && (in_req.mode == MODE_DECODE)) begin
          rp_nxt    = RPW'(in_req.address);
          start_nxt = in_req.address;
          rem_nxt   = '0;
          tl_nxt    = '0;
          hop_nxt   = '0;
          cons_nxt  = '0;
          jmp_nxt   = 1'b0;
          pos_nxt   = '0;
          cnt_nxt   = '0;
          grp_nxt   = '{default: '0};
          state_nxt = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        if (rp_past) begin
          err_nxt   = ERR_READ;
          state_nxt = S_ERR;
        end else begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (mrd_data == '0) begin
          if (!jmp_r) begin
            cons_nxt = rp_r[8:0] - start_r + 9'd1;
          end
          state_nxt = S_GRD;
        end else if (mrd_data[7:6] == TAG_POINTER) begin
          if (rp1_past) begin
            err_nxt   = ERR_READ;
            state_nxt = S_ERR;
          end else begin
            mrd_addr  = rp_r + RPW'(1);
            phi_nxt   = mrd_data[5:0];
            state_nxt = S_PTR;
          end
        end else if (mrd_data[7:6] != TAG_LABEL) begin
          err_nxt   = ERR_READ;
          state_nxt = S_ERR;
        end else if ((tl_r != '0) && name_full) begin
          err_nxt   = ERR_LONG;
          state_nxt = S_ERR;
        end else begin
          if (tl_r != '0) begin
            txt_we = 1'b1;
            txt_wd = CHAR_DOT;
            tl_nxt = tl_r + 8'd1;
          end
          rem_nxt   = mrd_data[5:0];
          rp_nxt    = rp_r + RPW'(1);
          state_nxt = S_LAB_RD;
        end
      end
      S_PTR: begin
        if (!jmp_r) begin
          cons_nxt = rp_r[8:0] - start_r + 9'd2;
          jmp_nxt  = 1'b1;
        end
        if (hop_r >= 5'(MAX_HOPS)) begin
          err_nxt   = ERR_HOPS;
          state_nxt = S_ERR;
        end else begin
          hop_nxt   = hop_r + 5'd1;
          rp_nxt    = {phi_r, mrd_data};
          state_nxt = S_HEAD_RD;
        end
      end
      S_LAB_RD: begin
        if (rp_past) begin
          err_nxt   = ERR_READ;
          state_nxt = S_ERR;
        end else begin
          state_nxt = S_LAB;
        end
      end
      S_LAB: begin
        if (name_full) begin
          err_nxt   = ERR_LONG;
          state_nxt = S_ERR;
        end else begin
          txt_we    = 1'b1;
          tl_nxt    = tl_r + 8'd1;
          rp_nxt    = rp_r + RPW'(1);
          rem_nxt   = rem_r - 6'd1;
          state_nxt = (rem_r == 6'd1) ? S_HEAD_RD : S_LAB_RD;
        end
      end
      S_GRD: begin
        if ((pos_r < tl_r) && (cnt_r != 3'd4)) begin
          state_nxt = S_GCH;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_GCH: begin
        grp_nxt[cnt_r[1:0]] = txt_rd_r;
        cnt_nxt   = cnt_r + 3'd1;
        pos_nxt   = pos_r + 8'd1;
        state_nxt = S_GRD;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_rsp_nxt.text_char0     = grp_r[0];
          out_rsp_nxt.text_char1     = grp_r[1];
          out_rsp_nxt.text_char2     = grp_r[2];
          out_rsp_nxt.text_char3     = grp_r[3];
          out_rsp_nxt.char_count     = cnt_r;
          out_rsp_nxt.last           = (pos_r == tl_r);
          out_rsp_nxt.consumed_bytes = (pos_r == tl_r) ? cons_r : 9'd0;
          out_rsp_nxt.error_code     = ERR_OK;
          grp_nxt   = '{default: '0};
          cnt_nxt   = '0;
          state_nxt = (pos_r == tl_r) ? S_IDLE : S_GRD;
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_rsp_nxt                = '0;
          out_rsp_nxt.last           = 1'b1;
          out_rsp_nxt.error_code     = err_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rp_r        <= '0;
      start_r     <= '0;
      rem_r       <= '0;
      tl_r        <= '0;
      hop_r       <= '0;
      cons_r      <= '0;
      jmp_r       <= 1'b0;
      pos_r       <= '0;
      cnt_r       <= '0;
      err_r       <= ERR_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      start_r     <= start_nxt;
      rem_r       <= rem_nxt;
      tl_r        <= tl_nxt;
      hop_r       <= hop_nxt;
      cons_r      <= cons_nxt;
      jmp_r       <= jmp_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phi_r     <= phi_nxt;
    grp_r     <= grp_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  always_ff @(posedge clk) begin
    if (txt_we) begin
      txt_mem[tl_r[TW-1:0]] <= txt_wd;
    end
    txt_rd_r <= txt_mem[pos_r[TW-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ===== rtl/core/dnsdec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS name decoder port checker
// Watches the top level ports for result rules, output holding and the hold-off after a decode.
// ----------------------------------------------------------------------------
module dnsdec_checker
  import dnsdec_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input in_req_t  in_req,
  input logic     out_valid,
  input logic     out_stall,
  input out_rsp_t out_rsp
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("result changed while stalled");

  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.error_code != ERR_OK) |->
      out_rsp.last && (out_rsp.char_count == 3'd0) && (out_rsp.consumed_bytes == 9'd0))
    else $error("error result carries text or a byte count");

  a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.last |->
      (out_rsp.char_count == 3'd4) && (out_rsp.consumed_bytes == 9'd0))
    else $error("result before the last one is not a full group");

  a_busy_after_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req.mode == MODE_DECODE) |=> in_stall)
    else $error("decode request did not hold off the next request");

endmodule

bind dns_name_label_decoder_top dnsdec_checker u_dnsdec_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_req   (in_req),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_rsp  (out_rsp)
);

// ===== bench/dns_name_label_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS name label decoder testbench
// Loads message bytes and decodes names built from labels and compression
// pointers, under changing handshake pressure. A scoreboard class predicts
// every text group of each decode and checks the block's results in order.
// ----------------------------------------------------------------------------
module dns_name_label_decoder_top_tb;
  import dnsdec_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int SCRATCH_BASE = 330;

  class dns_name_predictor;
    localparam int STORE_BYTES = 512;
    localparam int NAME_LIMIT  = 256;
    localparam int HOP_LIMIT   = 16;

    logic [7:0]  msg_bytes [STORE_BYTES];
    bit          byte_loaded [STORE_BYTES];
    int unsigned loaded_len;
    logic [7:0]  name_text [$];
    int unsigned name_consumed;
    bit          hit_hole;
    out_rsp_t    expected_groups [$];
    int unsigned groups_predicted;
    int unsigned mismatches;

    function new();
      foreach (msg_bytes[i]) begin
        msg_bytes[i] = 8'h00;
        byte_loaded[i] = 1'b0;
      end
      loaded_len = 0;
      groups_predicted = 0;
      mismatches = 0;
    endfunction

    function bit read_byte(int unsigned pos, output logic [7:0] val);
      if (pos >= loaded_len || pos >= STORE_BYTES) return 1'b0;
      if (!byte_loaded[pos]) hit_hole = 1'b1;
      val = msg_bytes[pos];
      return 1'b1;
    endfunction

    function logic [1:0] walk_name(int unsigned start);
      int unsigned rp;
      int unsigned hops;
      int unsigned remaining;
      logic [7:0]  b;
      logic [7:0]  b2;
      bit          jumped;
      rp = start;
      hops = 0;
      jumped = 1'b0;
      name_text.delete();
      name_consumed = 0;
      hit_hole = 1'b0;
      while (1'b1) begin
        if (!read_byte(rp, b)) return ERR_READ;
        if (b == 8'h00) begin
          if (!jumped) name_consumed = rp - start + 1;
          return ERR_OK;
        end
        if (b[7:6] == TAG_POINTER) begin
          if (!read_byte(rp + 1, b2)) return ERR_READ;
          if (!jumped) begin
            name_consumed = rp - start + 2;
            jumped = 1'b1;
          end
          if (hops >= HOP_LIMIT) return ERR_HOPS;
          hops++;
          rp = 32'({b[5:0], b2});
          continue;
        end
        if (b[7:6] != TAG_LABEL) return ERR_READ;
        if (name_text.size() != 0) begin
          if (name_text.size() >= NAME_LIMIT - 1) return ERR_LONG;
          name_text.push_back(CHAR_DOT);
        end
        remaining = 32'(b[5:0]);
        rp++;
        while (remaining != 0) begin
          if (!read_byte(rp, b2)) return ERR_READ;
          if (name_text.size() >= NAME_LIMIT - 1) return ERR_LONG;
          name_text.push_back(b2);
          rp++;
          remaining--;
        end
      end
      return ERR_READ;
    endfunction

    function bit start_is_safe(int unsigned start);
      void'(walk_name(start));
      return !hit_hole;
    endfunction

    function void note_request(in_req_t r);
      logic [1:0]  err;
      out_rsp_t    g;
      logic [7:0]  quad [4];
      int          n;
      int          cnt;
      if (r.mode == MODE_WRITE) begin
        msg_bytes[r.address] = r.data;
        byte_loaded[r.address] = 1'b1;
        if (int'(r.address) + 1 > loaded_len) loaded_len = int'(r.address) + 1;
        return;
      end
      err = walk_name(r.address);
      if (err != ERR_OK) begin
        g = '0;
        g.last = 1'b1;
        g.error_code = err;
        expected_groups.push_back(g);
        groups_predicted++;
        return;
      end
      n = (name_text.size() + 3) / 4;
      if (n == 0) n = 1;
      for (int k = 0; k < n; k++) begin
        cnt = 0;
        for (int j = 0; j < 4; j++) begin
          quad[j] = 8'h00;
          if (k * 4 + j < name_text.size()) begin
            quad[j] = name_text[k * 4 + j];
            cnt++;
          end
        end
        g.text_char0 = quad[0];
        g.text_char1 = quad[1];
        g.text_char2 = quad[2];
        g.text_char3 = quad[3];
        g.char_count = 3'(cnt);
        g.last = (k + 1 == n);
        g.consumed_bytes = (k + 1 == n) ? 9'(name_consumed) : 9'd0;
        g.error_code = ERR_OK;
        expected_groups.push_back(g);
        groups_predicted++;
      end
    endfunction

    function void check_field(string field, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_group(out_rsp_t got);
      out_rsp_t want;
      if (expected_groups.size() == 0) begin
        $error("result 0x%0h arrived with no decode outstanding", got);
        mismatches++;
        return;
      end
      want = expected_groups.pop_front();
      check_field("text_char0", 9'(want.text_char0), 9'(got.text_char0));
      check_field("text_char1", 9'(want.text_char1), 9'(got.text_char1));
      check_field("text_char2", 9'(want.text_char2), 9'(got.text_char2));
      check_field("text_char3", 9'(want.text_char3), 9'(got.text_char3));
      check_field("char_count", 9'(want.char_count), 9'(got.char_count));
      check_field("last", 9'(want.last), 9'(got.last));
      check_field("consumed_bytes", want.consumed_bytes, got.consumed_bytes);
      check_field("error_code", 9'(want.error_code), 9'(got.error_code));
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_rsp;

  dns_name_predictor name_pred = new();
  int unsigned send_idle_pct = 14;
  int unsigned stall_pct = 69;
  int unsigned requests_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned scratch_next = SCRATCH_BASE;
  int unsigned known_names [$];

  dns_name_label_decoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) name_pred.check_group(out_rsp);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_req(input in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (in_stall);
    name_pred.note_request(r);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_write(input int unsigned addr, input logic [7:0] value);
    in_req_t r;
    r.mode = MODE_WRITE;
    r.address = 9'(addr);
    r.data = value;
    send_req(r);
  endtask

  // A start whose walk would touch a never-written byte is replaced by the root name.
  task automatic decode_at(input int unsigned start);
    in_req_t r;
    if (!name_pred.start_is_safe(start)) start = 0;
    r.mode = MODE_DECODE;
    r.address = 9'(start);
    r.data = 8'($urandom_range(255));
    send_req(r);
  endtask

  task automatic load_bytes(input int unsigned base, input logic [7:0] seq [$]);
    foreach (seq[i]) send_write(base + i, seq[i]);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (name_pred.expected_groups.size() != 0);
  endtask

  task automatic load_and_decode_name();
    logic [7:0]  name_bytes [$];
    int unsigned label_pos [$];
    int unsigned labels;
    int unsigned len;
    int unsigned tail;
    int unsigned target;
    int unsigned base;
    labels = $urandom_range(3);
    for (int i = 0; i < labels; i++) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 5);
      label_pos.push_back(name_bytes.size());
      name_bytes.push_back(8'(len));
      repeat (len) name_bytes.push_back(8'($urandom_range(255)));
    end
    tail = $urandom_range(99);
    if (tail < 45) begin
      name_bytes.push_back(8'h00);
    end else begin
      if (tail < 85) target = known_names[$urandom_range(known_names.size() - 1)];
      else target = $urandom_range(16383);
      name_bytes.push_back({TAG_POINTER, 6'(target >> 8)});
      name_bytes.push_back(8'(target));
    end
    if (labels != 0 && $urandom_range(9) == 0)
      name_bytes[label_pos[$urandom_range(labels - 1)]] = 8'($urandom_range(64, 191));
    if (scratch_next + name_bytes.size() > 511) scratch_next = SCRATCH_BASE;
    base = scratch_next;
    load_bytes(base, name_bytes);
    scratch_next = base + name_bytes.size();
    known_names.push_back(base);
    decode_at(base);
    if (labels > 1 && $urandom_range(1) == 1)
      decode_at(base + label_pos[$urandom_range(1, labels - 1)]);
  endtask

  task automatic run_random_phase(input int unsigned send_pct, input int unsigned hold_pct);
    int unsigned req_mark;
    int unsigned group_mark;
    int unsigned pick;
    send_idle_pct = send_pct;
    stall_pct = hold_pct;
    req_mark = requests_sent;
    group_mark = name_pred.groups_predicted;
    while (requests_sent - req_mark < 16 || name_pred.groups_predicted - group_mark < 6) begin
      pick = $urandom_range(99);
      if (pick < 70) load_and_decode_name();
      else if (pick < 82) send_write($urandom_range(SCRATCH_BASE, 510), 8'($urandom_range(255)));
      else if (pick < 94) decode_at($urandom_range(511));
      else wait_for_drain();
    end
    wait_for_drain();
  endtask

  initial begin
    logic [7:0]  seq [$];
    int unsigned target;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    decode_at(0);
    send_write(0, 8'h00);
    decode_at(0);
    send_write(1, 8'hC0);
    decode_at(1);
    send_write(2, 8'h00);
    decode_at(1);
    seq = {8'h03, 8'h61, 8'h62, 8'h63, 8'h00};
    load_bytes(3, seq);
    decode_at(3);
    seq = {8'h02, 8'h78, 8'h79, 8'hC0, 8'h03};
    load_bytes(8, seq);
    decode_at(8);
    seq = {8'h04, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'hC0, 8'h08};
    load_bytes(13, seq);
    decode_at(13);
    seq = {8'h40, 8'hBF, 8'h05, 8'h71};
    load_bytes(20, seq);
    decode_at(20);
    decode_at(21);
    decode_at(22);

    // Each pointer of the chain points at the one before it; the first points at the root.
    for (int i = 0; i <= 16; i++) begin
      target = (i == 0) ? 0 : 24 + 2 * (i - 1);
      send_write(24 + 2 * i, {TAG_POINTER, 6'(target >> 8)});
      send_write(25 + 2 * i, 8'(target));
    end
    decode_at(54);
    decode_at(56);
    seq = {8'hC0, 8'h3C, 8'h01, 8'h7A, 8'h00};
    load_bytes(58, seq);
    decode_at(58);

    // A label of the largest length over the bytes already loaded, with a pointer
    // back to itself, grows the name past its limit at a dot and inside a label.
    send_write(0, 8'h3F);
    send_write(63, 8'h2D);
    send_write(64, 8'hC0);
    send_write(65, 8'h00);
    decode_at(0);
    seq = {8'h02, 8'h61, 8'h62, 8'hC0, 8'h00};
    load_bytes(66, seq);
    decode_at(66);
    send_write(0, 8'h00);
    decode_at(66);
    seq = {8'hFF, 8'hFF};
    load_bytes(71, seq);
    decode_at(71);
    send_write(511, 8'h00);
    decode_at(511);
    known_names = {0, 3, 8, 13, 58, 66};

    run_random_phase(14, 69);
    run_random_phase(69, 14);
    run_random_phase(0, 0);

    repeat (100) @(negedge clk);
    if (name_pred.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dnsdec_pkg.sv
rtl/core/dnsdec_msg_store.sv
rtl/core/dns_name_label_decoder_top.sv
rtl/core/dnsdec_checker.sv
bench/dns_name_label_decoder_top_tb.sv
